/* design/vdrm_pkg.sv */
// Shared types, constants and byte-swap helpers of the virtqueue ring manager.
`default_nettype none
package vdrm_pkg;

  localparam int unsigned QueueSize = 128;
  localparam int unsigned IdxW      = 7;
  localparam int unsigned CntW      = 8;
  localparam int unsigned RingAw    = 8;

  localparam logic [2:0] StSegTaken    = 3'd0;
  localparam logic [2:0] StChainPosted = 3'd1;
  localparam logic [2:0] StNoSpace     = 3'd2;
  localparam logic [2:0] StNothingDone = 3'd3;
  localparam logic [2:0] StBufReturned = 3'd4;

  localparam logic [15:0] FlagNext  = 16'h0001;
  localparam logic [15:0] FlagWrite = 16'h0002;

  localparam logic [7:0] RegLeMode   = 8'd0;
  localparam logic [7:0] RegEventIdx = 8'd1;

  localparam logic [CntW-1:0] QueueSizeCnt = 8'd128;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic res_nothing;
    logic res_nospace;
    logic add_start;
    logic add_exec;
    logic hv_start;
    logic hv_step;
    logic out_load;
  } vdrm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_harvest;
    logic none_done;
    logic reject;
    logic walk_last;
    logic out_busy;
  } vdrm_sts_t;

  function automatic logic [15:0] sw16(input logic [15:0] v, input logic en);
    sw16 = en ? {v[7:0], v[15:8]} : v;
  endfunction

  function automatic logic [31:0] sw32(input logic [31:0] v, input logic en);
    sw32 = en ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
  endfunction

  function automatic logic [63:0] sw64(input logic [63:0] v, input logic en);
    sw64 = en ? {v[7:0], v[15:8], v[23:16], v[31:24],
                 v[39:32], v[47:40], v[55:48], v[63:56]} : v;
  endfunction

endpackage
`default_nettype wire

/* design/vdrm_ctrl.sv */
// Sequencing state machine of the virtqueue ring manager.
`default_nettype none
module vdrm_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire vdrm_pkg::vdrm_sts_t sts_i,
  output vdrm_pkg::vdrm_cmd_t     cmd_o
);
  import vdrm_pkg::*;

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SDecide = 3'd1;
  localparam logic [2:0] SAdd    = 3'd2;
  localparam logic [2:0] SWalk   = 3'd3;
  localparam logic [2:0] SFinish = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = SDecide;
        end
      end
      SDecide: begin
        if (sts_i.is_harvest) begin
          if (sts_i.none_done) begin
            cmd_o.res_nothing = 1'b1;
            state_d           = SFinish;
          end else begin
            cmd_o.hv_start = 1'b1;
            state_d        = SWalk;
          end
        end else if (sts_i.reject) begin
          cmd_o.res_nospace = 1'b1;
          state_d           = SFinish;
        end else begin
          cmd_o.add_start = 1'b1;
          state_d         = SAdd;
        end
      end
      SAdd: begin
        cmd_o.add_exec = 1'b1;
        state_d        = SFinish;
      end
      SWalk: begin
        cmd_o.hv_step = 1'b1;
        if (sts_i.walk_last) begin
          state_d = SFinish;
        end
      end
      SFinish: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* design/vdrm_dp.sv */
// Datapath of the virtqueue ring manager: descriptor table, rings and counters.
`default_nettype none
module vdrm_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire vdrm_pkg::vdrm_cmd_t cmd_i,
  output vdrm_pkg::vdrm_sts_t      sts_o,
  input  wire logic                cfg_valid_i,
  input  wire logic [7:0]          cfg_index_i,
  input  wire logic                cfg_data_i,
  input  wire logic                command_i,
  input  wire logic [63:0]         seg_addr_i,
  input  wire logic [31:0]         seg_len_i,
  input  wire logic [6:0]          seg_position_i,
  input  wire logic [7:0]          out_count_i,
  input  wire logic [7:0]          chain_count_i,
  input  wire logic [31:0]         cookie_i,
  input  wire logic [15:0]         dev_used_index_i,
  input  wire logic [6:0]          used_id_i,
  input  wire logic [31:0]         used_len_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [2:0]               status_o,
  output logic [6:0]               head_index_o,
  output logic [15:0]              avail_index_o,
  output logic [31:0]              cookie_out_o,
  output logic [31:0]              done_len_o,
  output logic [7:0]               freed_count_o
);
  import vdrm_pkg::*;

  // Captured transaction.
  logic            cmd_q;
  logic [63:0]     addr_q;
  logic [31:0]     len_q;
  logic [6:0]      pos_q;
  logic [CntW-1:0] outc_q, cnt_q;
  logic [31:0]     cookie_q;
  logic [15:0]     dui_q;
  logic [IdxW-1:0] uid_q;
  logic [31:0]     ulen_q;

  // Ring state.
  logic            le_q, evt_q;
  logic [15:0]     ctr_q, ctr_d;
  logic [IdxW-1:0] free_top_q, free_top_d;
  logic [CntW-1:0] free_count_q, free_count_d;
  logic [15:0]     last_used_q, last_used_d;
  logic [IdxW-1:0] chain_head_q, chain_head_d;
  logic [IdxW-1:0] chain_cursor_q, chain_cursor_d;
  logic            open_q, open_d;
  logic [CntW-1:0] total_q, total_d, outs_q, outs_d, index_q, index_d;
  logic [IdxW-1:0] walk_idx_q, walk_idx_d;
  logic [CntW-1:0] freed_q, freed_d;

  // Result and output registers.
  logic [2:0]  res_status_q, res_status_d;
  logic [6:0]  res_head_q, res_head_d;
  logic [15:0] res_avail_q, res_avail_d;
  logic [31:0] res_cookie_q, res_cookie_d;
  logic [31:0] res_len_q, res_len_d;
  logic [7:0]  res_freed_q, res_freed_d;
  logic        out_valid_q;

  // Memories.
  logic [63:0] addr_mem [QueueSize];
  logic [31:0] len_mem [QueueSize];
  logic [15:0] flags_mem [QueueSize];
  logic [15:0] link_mem [QueueSize];
  logic [31:0] cookie_mem [QueueSize];
  logic [15:0] ring_mem [QueueSize+1];
  logic [QueueSize-1:0] link_vld_q, flags_vld_q;

  logic [CntW-1:0] total_in;
  logic [IdxW-1:0] cur;
  logic [CntW-1:0] index_nx;
  logic [15:0]     add_flags;
  logic            add_last;
  logic [15:0]     aidx, aidx1;

  logic            desc_we;
  logic [IdxW-1:0] desc_waddr;
  logic [63:0]     addr_wdata;
  logic [31:0]     len_wdata;
  logic [15:0]     flags_wdata;
  logic            link_we;
  logic [IdxW-1:0] link_waddr;
  logic [15:0]     link_wdata;
  logic [IdxW-1:0] rd_addr;
  logic            ring_we;
  logic [RingAw-1:0] ring_waddr;
  logic [15:0]     ring_wdata;
  logic            cookie_we;
  logic [IdxW-1:0] cookie_addr;
  logic [31:0]     cookie_wdata;
  logic [31:0]     cookie_rd_q;

  logic [15:0]     link_mem_q, flags_mem_q, link_byp_q, flags_byp_q;
  logic            link_byp_sel_q, flags_byp_sel_q, link_vld_sel_q, flags_vld_sel_q;
  logic [IdxW-1:0] rd_addr_q;
  logic [15:0]     link_rd, flags_rd, link_sw;
  logic [IdxW-1:0] nxt;
  logic            more;
  logic [CntW-1:0] freed_nx;
  logic [CntW:0]   fc_sum;
  logic            walk_last;
  logic [15:0]     used_nx;

  assign total_in = (cnt_q == '0) ? CntW'(1) : cnt_q;
  assign cur      = free_top_q;
  assign index_nx = index_q + CntW'(1);
  assign add_last = (index_nx >= total_q);
  always_comb begin
    add_flags = '0;
    if (index_q >= outs_q) add_flags = add_flags | FlagWrite;
    if (index_nx < total_q) add_flags = add_flags | FlagNext;
  end
  assign aidx  = sw16(ctr_q, le_q);
  assign aidx1 = aidx + 16'd1;

  // Descriptor reads; unwritten entries read as their reset value.
  assign link_rd  = link_byp_sel_q ? link_byp_q :
                    (link_vld_sel_q ? link_mem_q : {9'b0, rd_addr_q + IdxW'(1)});
  assign flags_rd = flags_byp_sel_q ? flags_byp_q :
                    (flags_vld_sel_q ? flags_mem_q : 16'h0000);
  assign link_sw  = sw16(link_rd, le_q);
  assign nxt      = link_sw[IdxW-1:0];
  assign more     = le_q ? flags_rd[8] : flags_rd[0];
  assign freed_nx = freed_q + CntW'(1);
  assign walk_last = !more || (freed_nx == QueueSizeCnt);
  assign fc_sum   = {1'b0, free_count_q} + {1'b0, freed_nx};
  assign used_nx  = last_used_q + 16'd1;

  assign sts_o.is_harvest = cmd_q;
  assign sts_o.none_done  = (last_used_q == dui_q);
  assign sts_o.reject     = !open_q && ((pos_q != '0) || (free_count_q < total_in));
  assign sts_o.walk_last  = walk_last;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  always_comb begin
    ctr_d          = ctr_q;
    free_top_d     = free_top_q;
    free_count_d   = free_count_q;
    last_used_d    = last_used_q;
    chain_head_d   = chain_head_q;
    chain_cursor_d = chain_cursor_q;
    open_d         = open_q;
    total_d        = total_q;
    outs_d         = outs_q;
    index_d        = index_q;
    walk_idx_d     = walk_idx_q;
    freed_d        = freed_q;
    res_status_d   = res_status_q;
    res_head_d     = res_head_q;
    res_avail_d    = res_avail_q;
    res_cookie_d   = res_cookie_q;
    res_len_d      = res_len_q;
    res_freed_d    = res_freed_q;
    desc_we        = 1'b0;
    desc_waddr     = cur;
    addr_wdata     = sw64(addr_q, le_q);
    len_wdata      = sw32(len_q, le_q);
    flags_wdata    = sw16(add_flags, le_q);
    link_we        = 1'b0;
    link_waddr     = chain_cursor_q;
    link_wdata     = sw16({9'b0, cur}, le_q);
    rd_addr        = nxt;
    ring_we        = 1'b0;
    ring_waddr     = {1'b0, aidx[IdxW-1:0]};
    ring_wdata     = sw16({9'b0, chain_head_q}, le_q);
    cookie_we      = 1'b0;
    cookie_addr    = uid_q;
    cookie_wdata   = '0;

    if (cmd_i.res_nothing || cmd_i.res_nospace) begin
      res_status_d = cmd_i.res_nothing ? StNothingDone : StNoSpace;
      res_head_d   = '0;
      res_avail_d  = '0;
      res_cookie_d = '0;
      res_len_d    = '0;
      res_freed_d  = '0;
    end

    if (cmd_i.add_start) begin
      // Reserve the whole chain on its first segment, then fetch the free link.
      rd_addr = free_top_q;
      if (!open_q) begin
        open_d       = 1'b1;
        total_d      = total_in;
        outs_d       = outc_q;
        index_d      = '0;
        free_count_d = free_count_q - total_in;
        chain_head_d = free_top_q;
        cookie_we    = 1'b1;
        cookie_addr  = free_top_q;
        cookie_wdata = cookie_q;
      end
    end

    if (cmd_i.add_exec) begin
      free_top_d     = link_rd[IdxW-1:0];
      link_we        = (index_q != '0);
      chain_cursor_d = cur;
      desc_we        = 1'b1;
      index_d        = index_nx;
      res_head_d     = chain_head_q;
      res_cookie_d   = '0;
      res_len_d      = '0;
      res_freed_d    = '0;
      if (add_last) begin
        open_d       = 1'b0;
        ring_we      = 1'b1;
        ctr_d        = sw16(aidx1, le_q);
        res_status_d = StChainPosted;
        res_avail_d  = aidx1;
      end else begin
        res_status_d = StSegTaken;
        res_avail_d  = '0;
      end
    end

    if (cmd_i.hv_start) begin
      rd_addr    = uid_q;
      cookie_we  = 1'b1;
      walk_idx_d = uid_q;
      freed_d    = '0;
    end

    if (cmd_i.hv_step) begin
      // Return this descriptor to the free list and follow the chain.
      desc_we     = 1'b1;
      desc_waddr  = walk_idx_q;
      addr_wdata  = '0;
      len_wdata   = '0;
      flags_wdata = '0;
      link_we     = 1'b1;
      link_waddr  = walk_idx_q;
      link_wdata  = {9'b0, free_top_q};
      free_top_d  = walk_idx_q;
      freed_d     = freed_nx;
      walk_idx_d  = nxt;
      if (walk_last) begin
        free_count_d = (fc_sum > {1'b0, QueueSizeCnt}) ? QueueSizeCnt : fc_sum[CntW-1:0];
        last_used_d  = used_nx;
        ring_we      = evt_q;
        ring_waddr   = RingAw'(QueueSize);
        ring_wdata   = sw16(used_nx, le_q);
        res_status_d = StBufReturned;
        res_head_d   = uid_q;
        res_avail_d  = '0;
        res_cookie_d = cookie_rd_q;
        res_len_d    = ulen_q;
        res_freed_d  = freed_nx;
      end
    end
  end

  // Memory ports.
  always_ff @(posedge clk_i) begin
    if (desc_we) begin
      addr_mem[desc_waddr]  <= addr_wdata;
      len_mem[desc_waddr]   <= len_wdata;
      flags_mem[desc_waddr] <= flags_wdata;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    if (cookie_we) begin
      cookie_mem[cookie_addr] <= cookie_wdata;
    end
    // Hold the cookie read at the start of a harvest for the whole walk.
    if (cmd_i.hv_start) begin
      cookie_rd_q <= cookie_mem[cookie_addr];
    end
    link_mem_q  <= link_mem[rd_addr];
    flags_mem_q <= flags_mem[rd_addr];
    link_byp_q  <= link_wdata;
    flags_byp_q <= flags_wdata;
    rd_addr_q   <= rd_addr;
  end

  // Read-after-write forwarding and per-entry written marks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q      <= '0;
      flags_vld_q     <= '0;
      link_byp_sel_q  <= 1'b0;
      flags_byp_sel_q <= 1'b0;
      link_vld_sel_q  <= 1'b0;
      flags_vld_sel_q <= 1'b0;
    end else begin
      link_byp_sel_q  <= link_we && (link_waddr == rd_addr);
      flags_byp_sel_q <= desc_we && (desc_waddr == rd_addr);
      link_vld_sel_q  <= link_vld_q[rd_addr];
      flags_vld_sel_q <= flags_vld_q[rd_addr];
      if (link_we) begin
        link_vld_q[link_waddr] <= 1'b1;
      end
      if (desc_we) begin
        flags_vld_q[desc_waddr] <= 1'b1;
      end
    end
  end

  // Transaction capture and result holding.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= command_i;
      addr_q   <= seg_addr_i;
      len_q    <= seg_len_i;
      pos_q    <= seg_position_i;
      outc_q   <= out_count_i;
      cnt_q    <= chain_count_i;
      cookie_q <= cookie_i;
      dui_q    <= dev_used_index_i;
      uid_q    <= used_id_i;
      ulen_q   <= used_len_i;
    end
    walk_idx_q   <= walk_idx_d;
    freed_q      <= freed_d;
    res_status_q <= res_status_d;
    res_head_q   <= res_head_d;
    res_avail_q  <= res_avail_d;
    res_cookie_q <= res_cookie_d;
    res_len_q    <= res_len_d;
    res_freed_q  <= res_freed_d;
    if (cmd_i.out_load) begin
      status_o      <= res_status_q;
      head_index_o  <= res_head_q;
      avail_index_o <= res_avail_q;
      cookie_out_o  <= res_cookie_q;
      done_len_o    <= res_len_q;
      freed_count_o <= res_freed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q           <= 1'b0;
      evt_q          <= 1'b0;
      ctr_q          <= '0;
      free_top_q     <= '0;
      free_count_q   <= QueueSizeCnt;
      last_used_q    <= '0;
      chain_head_q   <= '0;
      chain_cursor_q <= '0;
      open_q         <= 1'b0;
      total_q        <= '0;
      outs_q         <= '0;
      index_q        <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == RegLeMode)) begin
        le_q <= cfg_data_i;
      end
      if (cfg_valid_i && (cfg_index_i == RegEventIdx)) begin
        evt_q <= cfg_data_i;
      end
      ctr_q          <= ctr_d;
      free_top_q     <= free_top_d;
      free_count_q   <= free_count_d;
      last_used_q    <= last_used_d;
      chain_head_q   <= chain_head_d;
      chain_cursor_q <= chain_cursor_d;
      open_q         <= open_d;
      total_q        <= total_d;
      outs_q         <= outs_d;
      index_q        <= index_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* design/virtqueue_descriptor_ring_manager_core.sv */
// Top level of the split-virtqueue driver-side descriptor ring manager.
// Each input transaction is either an add (one scatter-gather segment of a
// chain) or a harvest (one used entry from the device), and each gives exactly
// one result transaction. One transaction is worked at a time. A taken add
// takes these steps from acceptance to the next acceptance: capture,
// decide/reserve, one descriptor-table read of the free link, then result
// hand-off. A rejected add or a harvest with nothing completed skips the table
// step and goes from decide to hand-off. A harvest walks every descriptor of
// the returned chain (at most 128): the walk reads one descriptor link and
// flag word per cycle through the single read port of the descriptor table.
// A result waiting at the output does not block acceptance; only the final
// hand-off waits for the output register while it is stalled. Configuration
// writes are always taken (cfg_ready_o is tied high) and are meant to arrive
// only while the block is idle. Register 0 selects byte-swapped (little-endian)
// storage, register 1 enables the used event index write when a chain returns.
// There is no clearing pass after reset: descriptor entries carry a written
// mark and read as their reset value until first written.
`default_nettype none
module virtqueue_descriptor_ring_manager_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic        cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        command_i,
  input  wire logic [63:0] seg_addr_i,
  input  wire logic [31:0] seg_len_i,
  input  wire logic [6:0]  seg_position_i,
  input  wire logic [7:0]  out_count_i,
  input  wire logic [7:0]  chain_count_i,
  input  wire logic [31:0] cookie_i,
  input  wire logic [15:0] dev_used_index_i,
  input  wire logic [6:0]  used_id_i,
  input  wire logic [31:0] used_len_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [6:0]       head_index_o,
  output logic [15:0]      avail_index_o,
  output logic [31:0]      cookie_out_o,
  output logic [31:0]      done_len_o,
  output logic [7:0]       freed_count_o
);
  import vdrm_pkg::*;

  vdrm_cmd_t cmd;
  vdrm_sts_t sts;

  // Take every configuration transaction immediately.
  assign cfg_ready_o = 1'b1;

  // Sequence each transaction through its phases.
  vdrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold descriptor table, rings, counters and the output register.
  vdrm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .command_i        (command_i),
    .seg_addr_i       (seg_addr_i),
    .seg_len_i        (seg_len_i),
    .seg_position_i   (seg_position_i),
    .out_count_i      (out_count_i),
    .chain_count_i    (chain_count_i),
    .cookie_i         (cookie_i),
    .dev_used_index_i (dev_used_index_i),
    .used_id_i        (used_id_i),
    .used_len_i       (used_len_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .head_index_o     (head_index_o),
    .avail_index_o    (avail_index_o),
    .cookie_out_o     (cookie_out_o),
    .done_len_o       (done_len_o),
    .freed_count_o    (freed_count_o)
  );

endmodule
`default_nettype wire

/* sim/tb_virtqueue_descriptor_ring_manager_core.sv */
// Self-checking testbench for the virtqueue descriptor ring manager core.
`timescale 1ns / 100ps
`default_nettype none
module tb_virtqueue_descriptor_ring_manager_core;
  import vdrm_pkg::*;

  localparam int Qs          = QueueSize;
  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 300;
  localparam int SettleTicks = 8;
  localparam logic [7:0] RegUnused = 8'hFF;

  // One input transaction, every field of the add and harvest commands.
  typedef struct packed {
    logic        cmd;
    logic [63:0] addr;
    logic [31:0] len;
    logic [6:0]  pos;
    logic [7:0]  outs;
    logic [7:0]  cnt;
    logic [31:0] cookie;
    logic [15:0] dui;
    logic [6:0]  uid;
    logic [31:0] ulen;
  } ring_cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  head;
    logic [15:0] avail;
    logic [31:0] cookie;
    logic [31:0] dlen;
    logic [7:0]  freed;
  } ring_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic [7:0] cfg_index = '0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  ring_cmd_t drv = '0;
  wire cfg_ready, in_ready, out_valid;
  wire [2:0] status;
  wire [6:0] head_index;
  wire [15:0] avail_index;
  wire [31:0] cookie_out, done_len;
  wire [7:0] freed_count;

  virtqueue_descriptor_ring_manager_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .command_i        (drv.cmd),
    .seg_addr_i       (drv.addr),
    .seg_len_i        (drv.len),
    .seg_position_i   (drv.pos),
    .out_count_i      (drv.outs),
    .chain_count_i    (drv.cnt),
    .cookie_i         (drv.cookie),
    .dev_used_index_i (drv.dui),
    .used_id_i        (drv.uid),
    .used_len_i       (drv.ulen),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .head_index_o     (head_index),
    .avail_index_o    (avail_index),
    .cookie_out_o     (cookie_out),
    .done_len_o       (done_len),
    .freed_count_o    (freed_count)
  );

  always #6 clk_i = ~clk_i;

  // Mirror of the ring state; links and flags are held in stored form.
  logic [15:0] ring_link [Qs];
  logic [15:0] ring_flags [Qs];
  logic [31:0] ring_tag [Qs];
  logic [15:0] avail_ctr, free_top, used_seen;
  int          free_cnt;
  logic [6:0]  open_head, open_cursor;
  bit          chain_open;
  int          open_total, open_outs, open_index;
  bit          le_mode;

  ring_result_t expected_q [$];
  logic [6:0]   posted_heads [$];
  ring_result_t last_result, got_r, exp_r;
  int           errors = 0;
  int           items_sent = 0;
  int           cycles = 0;
  bit           quiet = 1'b0;
  bit           hold_go = 1'b0, hold_seen = 1'b0;
  int           hold_left = 0;

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return le_mode ? {v[7:0], v[15:8]} : v;
  endfunction

  // Apply one command to the mirror and return the result it must produce.
  function automatic ring_result_t ring_predict(input ring_cmd_t c);
    ring_result_t r;
    int tot, freed;
    logic [15:0] cur, fl, aidx, idx, nxt;
    logic [6:0] id;
    bit more;
    r = '0;
    if (c.cmd) begin
      if (used_seen == c.dui) begin
        r.status = StNothingDone;
        return r;
      end
      id = c.uid;
      r.cookie = ring_tag[id];
      ring_tag[id] = '0;
      idx = {9'd0, id};
      freed = 0;
      // Walk the chain back onto the free list.
      while (freed < Qs) begin
        nxt = 16'(swap16(ring_link[idx[6:0]]) % Qs);
        more = (swap16(ring_flags[idx[6:0]]) & FlagNext) != 0;
        ring_flags[idx[6:0]] = '0;
        ring_link[idx[6:0]] = free_top;
        free_top = idx;
        freed++;
        if (!more) break;
        idx = nxt;
      end
      free_cnt = (free_cnt + freed > Qs) ? Qs : free_cnt + freed;
      used_seen = used_seen + 16'd1;
      r.status = StBufReturned;
      r.head = id;
      r.dlen = c.ulen;
      r.freed = (freed > 255) ? 8'd255 : freed[7:0];
      return r;
    end
    if (!chain_open) begin
      tot = c.cnt;
      if (c.pos != 0) begin
        r.status = StNoSpace;
        return r;
      end
      if (tot == 0) tot = 1;
      if (free_cnt < tot) begin
        r.status = StNoSpace;
        return r;
      end
      chain_open = 1'b1;
      open_total = tot;
      open_outs = c.outs;
      open_index = 0;
      free_cnt -= tot;
      open_head = 7'(free_top % Qs);
      ring_tag[open_head] = c.cookie;
    end
    cur = 16'(free_top % Qs);
    free_top = 16'(ring_link[cur[6:0]] % Qs);
    if (open_index > 0) ring_link[open_cursor] = swap16(cur);
    open_cursor = cur[6:0];
    fl = '0;
    if (open_index >= open_outs) fl |= FlagWrite;
    if (open_index + 1 < open_total) fl |= FlagNext;
    ring_flags[cur[6:0]] = swap16(fl);
    open_index++;
    r.head = open_head;
    if (open_index < open_total) begin
      r.status = StSegTaken;
    end else begin
      chain_open = 1'b0;
      aidx = swap16(avail_ctr) + 16'd1;
      avail_ctr = swap16(aidx);
      r.status = StChainPosted;
      r.avail = aidx;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  // Check every result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      got_r = {status, head_index, avail_index, cookie_out, done_len, freed_count};
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(got_r.status), 64'd0);
      end else begin
        exp_r = expected_q.pop_front();
        if (got_r.status !== exp_r.status)
          report_mismatch("status", 64'(got_r.status), 64'(exp_r.status));
        if (got_r.head !== exp_r.head)
          report_mismatch("head_index", 64'(got_r.head), 64'(exp_r.head));
        if (got_r.avail !== exp_r.avail)
          report_mismatch("avail_index", 64'(got_r.avail), 64'(exp_r.avail));
        if (got_r.cookie !== exp_r.cookie)
          report_mismatch("cookie_out", 64'(got_r.cookie), 64'(exp_r.cookie));
        if (got_r.dlen !== exp_r.dlen)
          report_mismatch("done_len", 64'(got_r.dlen), 64'(exp_r.dlen));
        if (got_r.freed !== exp_r.freed)
          report_mismatch("freed_count", 64'(got_r.freed), 64'(exp_r.freed));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_go && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 10);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one transaction, wait for the handshake and record its expectation.
  task automatic send_cmd(input ring_cmd_t c);
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    drv <= c;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    last_result = ring_predict(c);
    expected_q.push_back(last_result);
    items_sent++;
    if (last_result.status == StChainPosted) posted_heads.push_back(last_result.head);
  endtask

  // Hold input and wait until every result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == RegLeMode) le_mode = v;
  endtask

  function automatic ring_cmd_t mk_add(input logic [6:0] pos, input logic [7:0] outs,
                                       input logic [7:0] cnt);
    ring_cmd_t c;
    c.cmd = 1'b0;
    c.addr = {$urandom, $urandom};
    c.len = $urandom;
    c.pos = pos;
    c.outs = outs;
    c.cnt = cnt;
    c.cookie = $urandom;
    c.dui = 16'($urandom);
    c.uid = 7'($urandom);
    c.ulen = $urandom;
    return c;
  endfunction

  // Harvest: hit returns a posted chain, otherwise report nothing completed.
  task automatic harvest(input bit hit, input bit oldest);
    ring_cmd_t c;
    int k;
    c = mk_add(7'($urandom), 8'($urandom), 8'($urandom));
    c.cmd = 1'b1;
    c.dui = used_seen;
    if (hit && posted_heads.size() != 0) begin
      k = oldest ? 0 : $urandom_range(0, posted_heads.size() - 1);
      c.uid = posted_heads[k];
      posted_heads.delete(k);
      c.dui = used_seen + 16'($urandom_range(1, 65535));
    end
    send_cmd(c);
  endtask

  // Send a whole chain; a rejected first segment leaves the rest as strays.
  task automatic add_chain(input int len, input logic [7:0] outs, input bit mixed);
    int i;
    for (i = 0; i < len; i++) begin
      if (mixed && i > 0 && $urandom_range(0, 99) < 10) harvest(1'b1, 1'b0);
      send_cmd(mk_add(7'(i), outs, 8'(len)));
    end
  endtask

  task automatic run_traffic(input int n);
    int stop, pick, len;
    stop = items_sent + n;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (free_cnt < 24 && posted_heads.size() != 0) pick = 70;
      if (pick < 55) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
        add_chain(len, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, len + 1)),
                  1'b1);
      end else if (pick < 88) begin
        harvest(1'b1, $urandom_range(0, 1));
      end else if (pick < 94) begin
        harvest(1'b0, 1'b0);
      end else begin
        send_cmd(mk_add(7'($urandom_range(1, 127)), 8'($urandom), 8'($urandom)));
      end
    end
  endtask

  // Extremes of the fields and each special case of the command set.
  task automatic test_directed();
    ring_cmd_t c;
    harvest(1'b0, 1'b0);
    send_cmd(mk_add(7'd127, 8'd0, 8'd1));
    c = mk_add(7'd0, 8'd0, 8'd0);
    c.addr = '1;
    c.len = '1;
    c.cookie = '1;
    send_cmd(c);
    c = mk_add(7'd0, 8'd0, 8'd1);
    c.addr = '0;
    c.len = '0;
    c.cookie = '0;
    send_cmd(c);
    add_chain(3, 8'd1, 1'b0);
    add_chain(2, 8'd128, 1'b0);
    add_chain(2, 8'd255, 1'b0);
    send_cmd(mk_add(7'd0, 8'd0, 8'd255));
    send_cmd(mk_add(7'd1, 8'd0, 8'd255));
    send_cmd(mk_add(7'd0, 8'd3, 8'd128));
    send_cmd(mk_add(7'd0, 8'd0, 8'd2));
    harvest(1'b1, 1'b1);
    send_cmd(mk_add(7'd1, 8'd0, 8'd2));
    c = mk_add(7'd0, 8'd0, 8'd0);
    c.cmd = 1'b1;
    c.uid = posted_heads.pop_front();
    c.dui = used_seen ^ 16'hFFFF;
    c.ulen = '1;
    send_cmd(c);
    while (posted_heads.size() != 0) harvest(1'b1, 1'b1);
    drain_results();
  endtask

  // Each register setting, extremes first, with random traffic between.
  task automatic test_config_sweep();
    int m;
    for (m = 0; m < 4; m++) begin
      write_reg(RegLeMode, m[0]);
      write_reg(RegEventIdx, m[1]);
      run_traffic(55);
      drain_results();
    end
    write_reg(RegUnused, 1'b1);
    run_traffic(10);
    drain_results();
  endtask

  // Stall the output for a long stretch while input keeps coming.
  task automatic test_backpressure();
    int i;
    hold_go = 1'b1;
    quiet = 1'b1;
    for (i = 0; i < 16; i++) begin
      if (i[0]) harvest(1'b1, 1'b1);
      else add_chain(1, 8'd0, 1'b0);
    end
    quiet = 1'b0;
    drain_results();
  endtask

  task automatic test_random();
    run_traffic(80);
    quiet = 1'b1;
    run_traffic(50);
    quiet = 1'b0;
    run_traffic(20);
    drain_results();
  endtask

  initial begin : main
    int j;
    for (j = 0; j < Qs; j++) begin
      ring_link[j] = (j + 1 < Qs) ? 16'(j + 1) : 16'd0;
      ring_flags[j] = '0;
      ring_tag[j] = '0;
    end
    avail_ctr = '0;
    free_top = '0;
    used_seen = '0;
    free_cnt = Qs;
    chain_open = 1'b0;
    open_head = '0;
    open_cursor = '0;
    le_mode = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
